### rtl/kmu_pkg.sv
package kmu_pkg;

  localparam int unsigned MAX_CLUSTERS = 8;
  localparam int unsigned MAX_DIMS     = 4;
  localparam int unsigned COORD_WIDTH  = 16;

  localparam int unsigned CW = $clog2(MAX_CLUSTERS);
  localparam int unsigned DW = $clog2(MAX_DIMS);
  localparam int unsigned AW = CW + DW;

  localparam int unsigned SUM_WIDTH  = 32;
  localparam int unsigned CNT_WIDTH  = 16;
  localparam int unsigned DIST_WIDTH = 34;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_POINT  = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;

  localparam logic KIND_ASSIGN   = 1'b0;
  localparam logic KIND_CENTROID = 1'b1;

  localparam logic [1:0] REG_CLUSTERS = 2'd0;
  localparam logic [1:0] REG_DIMS     = 2'd1;

endpackage

### rtl/kmeans_assign_and_update_core.sv
// One Lloyd k-means iteration on 16-bit signed points. Load centroid
// coordinates with LOAD beats, then stream points one coordinate per POINT
// beat; the last coordinate of a point yields one assignment result (cluster
// and squared distance) and folds the point into that cluster's sums. An
// UPDATE beat replaces each centroid in use by the mean of its members
// (empty clusters keep their centroid) and returns every centroid coordinate.
// Centroids and sums live in two synchronous memories with registered reads.
// LOAD, plain POINT and unused beats leave the block idle. After a point's
// last coordinate the input drops ready for the distance scan (one centroid
// coordinate read a cycle, two pipeline stages), the read-modify-write on the
// sum memory (skipped when the count is saturated) and the load of the result
// register, which waits while an earlier result is still held. UPDATE reads,
// latches, divides with the 32-step bit-serial divider and emits each centroid
// coordinate in use; empty clusters skip the divider. Configuration writes are
// always accepted and the ready is tied high; write only while the block is
// idle.
module kmeans_assign_and_update_core import kmu_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [3:0]                    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    command_i,
  input  logic [2:0]                    cluster_index_i,
  input  logic [1:0]                    dim_index_i,
  input  logic signed [COORD_WIDTH-1:0] coord_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          result_kind_o,
  output logic [2:0]                    cluster_id_o,
  output logic [1:0]                    coord_pos_o,
  output logic signed [COORD_WIDTH-1:0] centroid_value_o,
  output logic [DIST_WIDTH-1:0]         min_distance_o,
  output logic                          last_item_o,
  output logic                          overflow_o
);

  localparam int unsigned DEPTH = MAX_CLUSTERS * MAX_DIMS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIST  = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_AEMIT = 3'd3;
  localparam logic [2:0] ST_URD   = 3'd4;
  localparam logic [2:0] ST_ULAT  = 3'd5;
  localparam logic [2:0] ST_UDIV  = 3'd6;
  localparam logic [2:0] ST_UOUT  = 3'd7;

  logic [2:0] st_q;
  logic [3:0] kreg_q;
  logic [2:0] dreg_q;
  logic [CW-1:0] k_last;
  logic [DW-1:0] d_last;

  // Clamp the in-use counts and keep the index of the last one.
  always_comb begin
    if (kreg_q == 4'd0) k_last = '0;
    else if (kreg_q > 4'(MAX_CLUSTERS)) k_last = CW'(MAX_CLUSTERS - 1);
    else k_last = CW'(kreg_q - 4'd1);
    if (dreg_q == 3'd0) d_last = '0;
    else if (dreg_q > 3'(MAX_DIMS)) d_last = DW'(MAX_DIMS - 1);
    else d_last = DW'(dreg_q - 3'd1);
  end

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kreg_q <= 4'd8;
      dreg_q <= 3'd4;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_CLUSTERS) kreg_q <= cfg_data_i;
      if (cfg_index_i == REG_DIMS) dreg_q <= cfg_data_i[2:0];
    end
  end

  // ---------------- memories ----------------
  logic signed [COORD_WIDTH-1:0] cent_mem [DEPTH];
  logic [DEPTH-1:0]              cent_vld_q;
  logic                          cent_we;
  logic [AW-1:0]                 cent_wa, cent_ra;
  logic signed [COORD_WIDTH-1:0] cent_wd, cent_rd_q, cent_val;
  logic                          cent_rv_q;

  logic signed [SUM_WIDTH-1:0] sum_mem [DEPTH];
  logic [DEPTH-1:0]            sum_vld_q;
  logic                        sum_we, sum_clr;
  logic [AW-1:0]               sum_wa, sum_ra;
  logic signed [SUM_WIDTH-1:0] sum_wd, sum_rd_q, sum_val;
  logic                        sum_rv_q;

  always_ff @(posedge clk_i) begin
    if (cent_we) cent_mem[cent_wa] <= cent_wd;
    cent_rd_q <= cent_mem[cent_ra];
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    sum_rd_q <= sum_mem[sum_ra];
  end

  // Entries never written read as zero; the sum valid bits drop at update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cent_vld_q <= '0;
      sum_vld_q  <= '0;
      cent_rv_q  <= 1'b0;
      sum_rv_q   <= 1'b0;
    end else begin
      cent_rv_q <= cent_vld_q[cent_ra];
      sum_rv_q  <= sum_vld_q[sum_ra];
      if (cent_we) cent_vld_q[cent_wa] <= 1'b1;
      if (sum_clr) sum_vld_q <= '0;
      else if (sum_we) sum_vld_q[sum_wa] <= 1'b1;
    end
  end

  assign cent_val = cent_rv_q ? cent_rd_q : '0;
  assign sum_val  = sum_rv_q ? sum_rd_q : '0;

  // ---------------- point state ----------------
  logic signed [COORD_WIDTH-1:0] pb_q [MAX_DIMS];
  logic [CNT_WIDTH-1:0]          cnt_q [MAX_CLUSTERS];
  logic                          ovf_q;

  // distance scan pipeline
  logic [CW-1:0] ic_q;
  logic [DW-1:0] id_q;
  logic          iss_done_q;
  logic          s1_v_q, s1_lastd_q, s1_lastall_q;
  logic [CW-1:0] s1_c_q;
  logic [DW-1:0] s1_d_q;
  logic          s2_v_q, s2_lastd_q, s2_lastall_q;
  logic [CW-1:0] s2_c_q;
  logic [DIST_WIDTH-1:0] sq_q, acc_q, acc_nx, best_d_q;
  logic [CW-1:0]         best_c_q;
  logic signed [COORD_WIDTH:0]     diff;
  logic signed [2*COORD_WIDTH+1:0] prod;
  logic          take;
  logic [CW-1:0]         best_c_nx;
  logic [DIST_WIDTH-1:0] best_d_nx;

  assign diff   = {pb_q[s1_d_q][COORD_WIDTH-1], pb_q[s1_d_q]}
                - {cent_val[COORD_WIDTH-1], cent_val};
  assign prod   = diff * diff;
  assign acc_nx = acc_q + sq_q;
  assign take   = s2_v_q && s2_lastd_q && ((s2_c_q == '0) || (acc_nx < best_d_q));
  assign best_c_nx = take ? s2_c_q : best_c_q;
  assign best_d_nx = take ? acc_nx : best_d_q;

  // sum accumulate sweep
  logic [DW-1:0] ad_q, aw_d_q;
  logic          add_done_q, aw_v_q;

  // update sweep
  logic [CW-1:0] uc_q;
  logic [DW-1:0] ud_q;
  logic          uneg_q, uwr_q, div_start, div_done;
  logic signed [COORD_WIDTH-1:0] uval_q;
  logic [SUM_WIDTH-1:0] div_q, sum_mag;

  assign sum_mag = sum_val[SUM_WIDTH-1] ? SUM_WIDTH'(-sum_val) : SUM_WIDTH'(sum_val);
  assign div_start = (st_q == ST_ULAT) && (cnt_q[uc_q] != '0);

  kmu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .divisor_i  (cnt_q[uc_q]),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  logic in_fire, slot_free, upd_last, emit_now;
  assign in_ready_o = (st_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_o || out_ready_i;
  assign upd_last   = (uc_q == k_last) && (ud_q == d_last);
  assign emit_now   = slot_free && (st_q == ST_AEMIT || st_q == ST_UOUT);

  // memory port steering
  always_comb begin
    cent_we = 1'b0;
    cent_wa = {cluster_index_i, dim_index_i};
    cent_wd = coord_value_i;
    if (in_fire && command_i == CMD_LOAD) begin
      cent_we = 1'b1;
    end else if (st_q == ST_UOUT && slot_free && uwr_q) begin
      cent_we = 1'b1;
      cent_wa = {uc_q, ud_q};
      cent_wd = uval_q;
    end
    cent_ra = (st_q == ST_DIST) ? {ic_q, id_q} : {uc_q, ud_q};
    sum_ra  = (st_q == ST_ADD) ? {best_c_q, ad_q} : {uc_q, ud_q};
    sum_we  = aw_v_q;
    sum_wa  = {best_c_q, aw_d_q};
    sum_wd  = sum_val + SUM_WIDTH'(pb_q[aw_d_q]);
    sum_clr = (st_q == ST_UOUT) && slot_free && upd_last;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && command_i == CMD_POINT && dim_index_i <= d_last)
      pb_q[dim_index_i] <= coord_value_i;
    sq_q <= DIST_WIDTH'(prod);
    s1_c_q <= ic_q;
    s1_d_q <= id_q;
    s1_lastd_q <= (id_q == d_last);
    s1_lastall_q <= (id_q == d_last) && (ic_q == k_last);
    s2_c_q <= s1_c_q;
    s2_lastd_q <= s1_lastd_q;
    s2_lastall_q <= s1_lastall_q;
    best_c_q <= best_c_nx;
    best_d_q <= best_d_nx;
    aw_d_q <= ad_q;
    if (st_q == ST_ULAT) begin
      uneg_q <= sum_val[SUM_WIDTH-1];
      uval_q <= cent_val;
      uwr_q  <= 1'b0;
    end else if (div_done) begin
      uval_q <= uneg_q ? COORD_WIDTH'(-div_q) : COORD_WIDTH'(div_q);
      uwr_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ovf_q       <= 1'b0;
      cnt_q       <= '{default: '0};
      ic_q        <= '0;
      id_q        <= '0;
      iss_done_q  <= 1'b1;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      acc_q       <= '0;
      ad_q        <= '0;
      add_done_q  <= 1'b1;
      aw_v_q      <= 1'b0;
      uc_q        <= '0;
      ud_q        <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && !emit_now) out_valid_o <= 1'b0;
      s1_v_q <= (st_q == ST_DIST) && !iss_done_q;
      s2_v_q <= s1_v_q;
      aw_v_q <= (st_q == ST_ADD) && !add_done_q;
      if (s2_v_q) acc_q <= s2_lastd_q ? '0 : acc_nx;

      unique case (st_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (command_i == CMD_POINT && dim_index_i == d_last) begin
              st_q <= ST_DIST;
              ic_q <= '0;
              id_q <= '0;
              iss_done_q <= 1'b0;
              acc_q <= '0;
            end else if (command_i == CMD_UPDATE) begin
              st_q <= ST_URD;
              uc_q <= '0;
              ud_q <= '0;
            end
          end
        end
        ST_DIST: begin
          // issue one centroid coordinate a cycle
          if (!iss_done_q) begin
            if (id_q == d_last) begin
              id_q <= '0;
              if (ic_q == k_last) iss_done_q <= 1'b1;
              else ic_q <= ic_q + 1'b1;
            end else begin
              id_q <= id_q + 1'b1;
            end
          end
          if (s2_v_q && s2_lastall_q) begin
            if (cnt_q[best_c_nx] == '1) begin
              ovf_q <= 1'b1;
              st_q <= ST_AEMIT;
            end else begin
              cnt_q[best_c_nx] <= cnt_q[best_c_nx] + 1'b1;
              ad_q <= '0;
              add_done_q <= 1'b0;
              st_q <= ST_ADD;
            end
          end
        end
        ST_ADD: begin
          if (!add_done_q) begin
            if (ad_q == d_last) add_done_q <= 1'b1;
            else ad_q <= ad_q + 1'b1;
          end
          if (aw_v_q && aw_d_q == d_last) st_q <= ST_AEMIT;
        end
        ST_AEMIT: begin
          if (slot_free) begin
            out_valid_o      <= 1'b1;
            result_kind_o    <= KIND_ASSIGN;
            cluster_id_o     <= 3'(best_c_q);
            coord_pos_o      <= '0;
            centroid_value_o <= '0;
            min_distance_o   <= best_d_q;
            last_item_o      <= 1'b1;
            overflow_o       <= ovf_q;
            st_q <= ST_IDLE;
          end
        end
        ST_URD:  st_q <= ST_ULAT;
        ST_ULAT: st_q <= (cnt_q[uc_q] == '0) ? ST_UOUT : ST_UDIV;
        ST_UDIV: if (div_done) st_q <= ST_UOUT;
        ST_UOUT: begin
          if (slot_free) begin
            out_valid_o      <= 1'b1;
            result_kind_o    <= KIND_CENTROID;
            cluster_id_o     <= 3'(uc_q);
            coord_pos_o      <= 2'(ud_q);
            centroid_value_o <= uval_q;
            min_distance_o   <= '0;
            last_item_o      <= upd_last;
            overflow_o       <= ovf_q;
            if (upd_last) begin
              cnt_q <= '{default: '0};
              ovf_q <= 1'b0;
              st_q  <= ST_IDLE;
            end else begin
              st_q <= ST_URD;
              if (ud_q == d_last) begin
                ud_q <= '0;
                uc_q <= uc_q + 1'b1;
              end else begin
                ud_q <= ud_q + 1'b1;
              end
            end
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> (!s1_v_q && !s2_v_q && !aw_v_q))
    else $error("pipeline busy in idle");
  a_div_in_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (st_q == ST_UDIV)) else $error("stray divider done");
  a_sum_write_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_we |-> (st_q == ST_ADD || st_q == ST_AEMIT)) else $error("stray sum write");
  a_emit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == KIND_CENTROID) |-> (min_distance_o == '0))
    else $error("distance on centroid beat");
`endif

endmodule

### rtl/kmu_div.sv
module kmu_div import kmu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [SUM_WIDTH-1:0] dividend_i,
  input  logic [CNT_WIDTH-1:0] divisor_i,
  output logic                 done_o,
  output logic [SUM_WIDTH-1:0] quot_o
);

  localparam int unsigned SW = $clog2(SUM_WIDTH);

  logic                 busy_q;
  logic [SW-1:0]        cnt_q;
  logic [SUM_WIDTH-1:0] quo_q;
  logic [CNT_WIDTH-1:0] rem_q, den_q;
  logic [CNT_WIDTH:0]   trial;
  logic                 fits;

  // One quotient bit per cycle, restoring.
  assign trial = {rem_q, quo_q[SUM_WIDTH-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= !start_i && busy_q && (cnt_q == SW'(SUM_WIDTH - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == SW'(SUM_WIDTH - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_WIDTH-2:0], fits};
      rem_q <= fits ? CNT_WIDTH'(trial - {1'b0, den_q}) : trial[CNT_WIDTH-1:0];
    end
  end

  assign quot_o = quo_q;

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_q)) else $error("done without busy");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("start while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
`endif

endmodule

### tb/tb_kmeans_assign_and_update_core.sv
module tb_kmeans_assign_and_update_core;
  import kmu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_NONE   = 2'd3;   // unused opcode, must be a no-op
  localparam logic [1:0] REG_UNUSED = 2'd2;   // unmapped register index
  localparam int         CYCLE_CAP  = 3000000;
  localparam int         DRAIN      = 200;    // covers a trailing distance scan
  localparam int         COUNT_TOP  = 65535;

  typedef struct {
    logic [1:0]        cmd;
    logic [2:0]        ci;
    logic [1:0]        di;
    logic signed [15:0] val;
    int                gap;
  } beat_t;

  typedef struct {
    logic               kind;
    logic [2:0]         id;
    logic [1:0]         pos;
    logic signed [15:0] val;
    logic [33:0]        sq_dist;
    logic               last;
    logic               ovf;
  } res_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [3:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [1:0] command_i;
  logic [2:0] cluster_index_i;
  logic [1:0] dim_index_i;
  logic signed [15:0] coord_value_i;
  logic out_valid_o, out_ready_i;
  logic result_kind_o;
  logic [2:0] cluster_id_o;
  logic [1:0] coord_pos_o;
  logic signed [15:0] centroid_value_o;
  logic [DIST_WIDTH-1:0] min_distance_o;
  logic last_item_o, overflow_o;

  kmeans_assign_and_update_core uut (.*);

  // Beats waiting to be offered, and results still owed by the block.
  beat_t pending_q[$];
  res_t  owed_q[$];
  int    fails = 0;
  int    cycles = 0;
  bit    idle_en = 1;   // random gaps on both sides when set
  logic  hold_arm = 0;
  logic  hold_done;
  int    hold_left;

  // Shadow of the block: registers and stores.
  logic [3:0]         k_reg = 4'd8;
  logic [2:0]         d_reg = 3'd4;
  logic signed [15:0] cent_m [MAX_CLUSTERS][MAX_DIMS];
  logic signed [15:0] pbuf_m [MAX_DIMS];
  longint             sums_m [MAX_CLUSTERS][MAX_DIMS];
  int                 cnt_m  [MAX_CLUSTERS];
  bit                 ovf_m;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic int k_used();
    if (k_reg == 0) return 1;
    if (k_reg > MAX_CLUSTERS) return MAX_CLUSTERS;
    return k_reg;
  endfunction

  function automatic int d_used();
    if (d_reg == 0) return 1;
    if (d_reg > MAX_DIMS) return MAX_DIMS;
    return d_reg;
  endfunction

  // Apply one accepted beat to the shadow state and queue what it yields.
  task automatic assign_and_update(beat_t b);
    int     kk, dd, best;
    longint sq_sum, best_dist, diff;
    res_t   r;
    kk = k_used();
    dd = d_used();
    case (b.cmd)
      CMD_LOAD: cent_m[b.ci][b.di] = b.val;
      CMD_POINT: begin
        if (b.di < dd) begin
          pbuf_m[b.di] = b.val;
          if (b.di == dd - 1) begin
            best = 0;
            best_dist = 0;
            for (int c = 0; c < kk; c++) begin
              sq_sum = 0;
              for (int d = 0; d < dd; d++) begin
                diff = longint'(pbuf_m[d]) - longint'(cent_m[c][d]);
                sq_sum += diff * diff;
              end
              // strict compare: lowest index keeps a tie
              if (c == 0 || sq_sum < best_dist) begin
                best_dist = sq_sum;
                best = c;
              end
            end
            if (cnt_m[best] >= COUNT_TOP) ovf_m = 1;
            else begin
              cnt_m[best]++;
              for (int d = 0; d < dd; d++) sums_m[best][d] += longint'(pbuf_m[d]);
            end
            r = '{KIND_ASSIGN, best[2:0], 2'd0, 16'sd0, best_dist[33:0], 1'b1, ovf_m};
            owed_q = {owed_q, r};
          end
        end
      end
      CMD_UPDATE: begin
        for (int c = 0; c < kk; c++)
          for (int d = 0; d < dd; d++) begin
            // empty cluster keeps its centroid
            if (cnt_m[c] > 0) cent_m[c][d] = 16'(sums_m[c][d] / longint'(cnt_m[c]));
            r = '{KIND_CENTROID, c[2:0], d[1:0], cent_m[c][d], 34'd0,
                  (c == kk - 1 && d == dd - 1), ovf_m};
            owed_q = {owed_q, r};
          end
        for (int c = 0; c < MAX_CLUSTERS; c++) begin
          cnt_m[c] = 0;
          for (int d = 0; d < MAX_DIMS; d++) sums_m[c][d] = 0;
        end
        ovf_m = 0;
      end
      default: ;
    endcase
  endtask

  // Driver: offer queued beats, predict each one at acceptance.
  int    wait_cnt;
  beat_t cur;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      command_i       <= CMD_NONE;
      cluster_index_i <= '0;
      dim_index_i     <= '0;
      coord_value_i   <= '0;
      wait_cnt = 0;
    end else begin
      if (in_valid_i && in_ready_o) assign_and_update(cur);
      if (!in_valid_i || in_ready_o) begin
        if (pending_q.size() > 0 && wait_cnt >= pending_q[0].gap) begin
          cur = pending_q.pop_front();
          wait_cnt = 0;
          in_valid_i      <= 1'b1;
          command_i       <= cur.cmd;
          cluster_index_i <= cur.ci;
          dim_index_i     <= cur.di;
          coord_value_i   <= cur.val;
        end else begin
          if (pending_q.size() > 0) wait_cnt++;
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed once by the stimulus.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: stall at random, compare each result beat with the oldest owed one.
  int   stall_cnt;
  res_t want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (owed_q.size() == 0) begin
          $error("result beat with nothing owed: cluster_id %0d", cluster_id_o);
          fails++;
        end else begin
          want = owed_q.pop_front();
          if (result_kind_o !== want.kind) begin
            $error("result_kind exp %0d got %0d", want.kind, result_kind_o); fails++;
          end
          if (cluster_id_o !== want.id) begin
            $error("cluster_id exp %0d got %0d", want.id, cluster_id_o); fails++;
          end
          if (coord_pos_o !== want.pos) begin
            $error("coord_pos exp %0d got %0d", want.pos, coord_pos_o); fails++;
          end
          if (centroid_value_o !== want.val) begin
            $error("centroid_value exp %0d got %0d", want.val, centroid_value_o); fails++;
          end
          if (min_distance_o !== want.sq_dist) begin
            $error("min_distance exp %0d got %0d", want.sq_dist, min_distance_o); fails++;
          end
          if (last_item_o !== want.last) begin
            $error("last_item exp %0d got %0d", want.last, last_item_o); fails++;
          end
          if (overflow_o !== want.ovf) begin
            $error("overflow exp %0d got %0d", want.ovf, overflow_o); fails++;
          end
        end
        stall_cnt = (idle_en && $urandom_range(0, 2) != 0) ? $urandom_range(0, 11) : 0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
      end
      out_ready_i <= (stall_cnt == 0) && (hold_left == 0);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("kmeans_assign_and_update_core test failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_beat(logic [1:0] cmd, logic [2:0] ci, logic [1:0] di,
                           logic signed [15:0] val);
    beat_t b;
    b.cmd = cmd;
    b.ci  = ci;
    b.di  = di;
    b.val = val;
    b.gap = (idle_en && $urandom_range(0, 2) != 0) ? $urandom_range(0, 11) : 0;
    pending_q = {pending_q, b};
  endtask

  // A whole point, coordinates in order, every one set to val.
  task automatic push_flat_point(logic signed [15:0] val);
    for (int d = 0; d < d_used(); d++) push_beat(CMD_POINT, 3'($urandom), d[1:0], val);
  endtask

  task automatic push_rand_point();
    for (int d = 0; d < d_used(); d++)
      push_beat(CMD_POINT, 3'($urandom), d[1:0], pick_coord());
  endtask

  // Hold until the block has drained everything, then let it settle.
  task automatic wait_quiet();
    while (pending_q.size() > 0 || in_valid_i || owed_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_CLUSTERS) k_reg = data;
    else if (idx == REG_DIMS) d_reg = data[2:0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic rand_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r < 12) push_rand_point();
      else if (r < 15) push_beat(CMD_LOAD, 3'($urandom), 2'($urandom), pick_coord());
      else if (r == 15) push_beat(CMD_UPDATE, 3'($urandom), 2'($urandom), 16'($urandom));
      else push_beat(2'($urandom), 3'($urandom), 2'($urandom), pick_coord()); // any opcode
    end
    push_beat(CMD_UPDATE, 3'($urandom), 2'($urandom), 16'($urandom));
  endtask

  initial begin
    for (int c = 0; c < MAX_CLUSTERS; c++) begin
      cnt_m[c] = 0;
      for (int d = 0; d < MAX_DIMS; d++) begin
        cent_m[c][d] = 0;
        sums_m[c][d] = 0;
      end
    end
    for (int d = 0; d < MAX_DIMS; d++) pbuf_m[d] = 0;
    ovf_m = 0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_CLUSTERS;
    cfg_data_i  = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, ties, empty clusters, the unused opcode.
    for (int d = 0; d < MAX_DIMS; d++) begin
      push_beat(CMD_LOAD, 3'd1, d[1:0], 16'sd32767);
      push_beat(CMD_LOAD, 3'd7, d[1:0], -16'sd32768);
    end
    push_flat_point(16'sd32767);
    push_flat_point(-16'sd32768);
    push_flat_point(16'sd0);              // ties several zero centroids: lowest wins
    push_beat(CMD_NONE, 3'd7, 2'd3, -16'sd1);
    push_beat(CMD_UPDATE, 3'd0, 2'd0, 16'sd0);  // most clusters empty
    wait_quiet();

    // Range-clamped settings, then the far-distance case with one cluster.
    write_reg(REG_CLUSTERS, 4'd0);
    write_reg(REG_DIMS, 4'd7);
    push_beat(CMD_LOAD, 3'd0, 2'd0, 16'sd32767);
    push_beat(CMD_LOAD, 3'd0, 2'd1, 16'sd32767);
    push_beat(CMD_LOAD, 3'd0, 2'd2, 16'sd32767);
    push_beat(CMD_LOAD, 3'd0, 2'd3, 16'sd32767);
    push_flat_point(-16'sd32768);
    push_beat(CMD_UPDATE, 3'd0, 2'd0, 16'sd0);
    wait_quiet();

    write_reg(REG_CLUSTERS, 4'd15);
    write_reg(REG_DIMS, 4'd0);
    push_beat(CMD_POINT, 3'd0, 2'd2, 16'sd5);   // beyond the dims in use: dropped
    rand_phase(20);
    wait_quiet();

    write_reg(REG_UNUSED, 4'd3);
    write_reg(REG_CLUSTERS, 4'd3);
    write_reg(REG_DIMS, 4'd2);
    rand_phase(30);
    wait_quiet();

    // Back-pressure: receiver holds off while the sender streams without gaps.
    idle_en = 0;
    write_reg(REG_CLUSTERS, 4'd8);
    write_reg(REG_DIMS, 4'd4);
    hold_arm <= 1'b1;
    rand_phase(25);
    wait_quiet();
    idle_en = 1;

    write_reg(REG_CLUSTERS, 4'd1);
    write_reg(REG_DIMS, 4'd1);
    rand_phase(30);
    wait_quiet();

    write_reg(REG_CLUSTERS, 4'd5);
    write_reg(REG_DIMS, 4'd3);
    rand_phase(30);
    wait_quiet();

    write_reg(REG_CLUSTERS, 4'd8);
    write_reg(REG_DIMS, 4'd4);
    rand_phase(25);
    wait_quiet();

    if (fails == 0) begin
      $display("kmeans_assign_and_update_core test passed");
    end else begin
      $display("kmeans_assign_and_update_core test failed");
    end
    $finish;
  end

endmodule
